>>> design/ggc_pkg.sv
package ggc_pkg;

   localparam int MAX_NODES_DEFAULT  = 256;
   localparam int MAX_COLORS_DEFAULT = 64;

   localparam int NEIGHBOR_W   = 8;
   localparam int INDEX_W      = 8;
   localparam int COLOR_W      = 6;
   localparam int NODE_COUNT_W = 9;

   localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 9'd256;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic               overflow;
   } pick_type;

endpackage

>>> design/greedy_graph_coloring_unit.sv
// A request is registered at acceptance, with its color store read, and its
// result, if any, is registered in the response registers when it leaves s1.
// Throughput: one request per cycle while req_stall is low; the color store
// read and the color choice each take one register stage, latest write forwarded.
// Reset (synchronous, active high) clears control state, the color map,
// the current node and sets node_count to 256; no clearing pass is needed.
module greedy_graph_coloring_unit #(
   parameter int MAX_NODES  = ggc_pkg::MAX_NODES_DEFAULT,
   parameter int MAX_COLORS = ggc_pkg::MAX_COLORS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ggc_pkg::NEIGHBOR_W-1:0]     req_neighbor,
   input  logic                               req_neighbor_valid,
   input  logic                               req_last_of_node,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ggc_pkg::INDEX_W-1:0]        rsp_node_index,
   output logic [ggc_pkg::COLOR_W-1:0]        rsp_node_color,
   output logic                               rsp_color_overflow,

   input  logic                               csr_write_enable,
   input  logic [ggc_pkg::NODE_COUNT_W-1:0]   csr_write_data
);

   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int CMP_W  = (NODE_W > ggc_pkg::INDEX_W ? NODE_W : ggc_pkg::INDEX_W) + 2;

   // nodes below the current one are exactly the colored ones of this graph
   logic [NODE_W-1:0]                 node_ff, node_in;
   logic [MAX_COLORS-1:0]             used_ff, used_in;
   logic [ggc_pkg::NODE_COUNT_W-1:0]  count_ff, count_in;

   logic                              s1_valid_ff, s1_valid_in;
   logic [ggc_pkg::NEIGHBOR_W-1:0]    s1_nb_ff;
   logic                              s1_nbv_ff;
   logic                              s1_last_ff;
   logic                              s1_fwd_ff;
   logic [ggc_pkg::COLOR_W-1:0]       s1_fwd_color_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ggc_pkg::INDEX_W-1:0]       rsp_index_ff;
   logic [ggc_pkg::COLOR_W-1:0]       rsp_color_ff;
   logic                              rsp_overflow_ff;

   logic                              accept;
   logic                              s1_adv;
   logic                              s1_fire;
   logic                              wr_en;
   logic [NODE_W-1:0]                 rd_addr;
   logic [CMP_W-1:0]                  nb_wide;
   logic [CMP_W-1:0]                  node_wide;
   logic [CMP_W-1:0]                  node_next;
   logic [CMP_W-1:0]                  eff_count;
   logic                              wrap;
   logic [ggc_pkg::COLOR_W-1:0]       ram_q;
   logic [ggc_pkg::COLOR_W-1:0]       nb_color;
   logic                              hit;
   logic [MAX_COLORS-1:0]             map_now;
   ggc_pkg::pick_type                 pick;

   assign s1_adv    = !rsp_valid_ff || !rsp_stall || !s1_last_ff;
   assign s1_fire   = s1_valid_ff && s1_adv;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;
   assign wr_en     = s1_fire && s1_last_ff;

   assign nb_wide   = CMP_W'(req_neighbor);
   assign rd_addr   = nb_wide[NODE_W-1:0];
   assign node_wide = CMP_W'(node_ff);
   assign node_next = node_wide + CMP_W'(1);

   always_comb begin
      if (count_ff == '0) begin
         eff_count = CMP_W'(1);
      end else if (CMP_W'(count_ff) > CMP_W'(MAX_NODES)) begin
         eff_count = CMP_W'(MAX_NODES);
      end else begin
         eff_count = CMP_W'(count_ff);
      end
   end

   assign wrap = node_next >= eff_count;

   ggc_ram #(
      .WIDTH (ggc_pkg::COLOR_W),
      .DEPTH (MAX_NODES)
   ) u_color_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (node_ff),
      .wr_data (pick.color),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign nb_color = s1_fwd_ff ? s1_fwd_color_ff : ram_q;
   assign hit      = s1_nbv_ff && (CMP_W'(s1_nb_ff) < node_wide);
   assign map_now  = used_ff | (hit ? (MAX_COLORS'(1) << nb_color) : '0);

   ggc_color_pick #(
      .MAX_COLORS (MAX_COLORS)
   ) u_color_pick (
      .used_map (map_now),
      .pick     (pick)
   );

   always_comb begin
      count_in     = csr_write_enable ? csr_write_data : count_ff;
      s1_valid_in  = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      used_in      = used_ff;
      node_in      = node_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_fire) begin
         used_in = s1_last_ff ? '0 : map_now;
      end
      if (wr_en) begin
         node_in      = wrap ? '0 : node_next[NODE_W-1:0];
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff      <= '0;
         used_ff      <= '0;
         count_ff     <= ggc_pkg::NODE_COUNT_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         node_ff      <= node_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_nb_ff        <= req_neighbor;
         s1_nbv_ff       <= req_neighbor_valid;
         s1_last_ff      <= req_last_of_node;
         s1_fwd_ff       <= wr_en && (node_ff == rd_addr);
         s1_fwd_color_ff <= pick.color;
      end
      if (wr_en) begin
         rsp_index_ff    <= node_wide[ggc_pkg::INDEX_W-1:0];
         rsp_color_ff    <= pick.color;
         rsp_overflow_ff <= pick.overflow;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_node_index     = rsp_index_ff;
   assign rsp_node_color     = rsp_color_ff;
   assign rsp_color_overflow = rsp_overflow_ff;

endmodule

>>> design/ggc_ram.sv
module ggc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> design/ggc_color_pick.sv
module ggc_color_pick #(
   parameter int MAX_COLORS = ggc_pkg::MAX_COLORS_DEFAULT
) (
   input  logic [MAX_COLORS-1:0] used_map,
   output ggc_pkg::pick_type     pick
);

   // lowest clear bit; saturates at the top color when all are set
   always_comb begin
      pick.color    = ggc_pkg::COLOR_W'(MAX_COLORS - 1);
      pick.overflow = 1'b1;
      for (int i = MAX_COLORS - 1; i >= 0; i--) begin
         if (!used_map[i]) begin
            pick.color    = ggc_pkg::COLOR_W'(i);
            pick.overflow = 1'b0;
         end
      end
   end

endmodule

>>> design/ggc_checker.sv
module ggc_protocol_checker #(
   parameter int MAX_COLORS = ggc_pkg::MAX_COLORS_DEFAULT
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [ggc_pkg::INDEX_W-1:0]  rsp_node_index,
   input logic [ggc_pkg::COLOR_W-1:0]  rsp_node_color,
   input logic                         rsp_color_overflow
);

   logic                        seen_ff;
   logic [ggc_pkg::INDEX_W-1:0] last_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         seen_ff <= 1'b1;
      end
      if (rsp_valid && !rsp_stall) begin
         last_index_ff <= rsp_node_index;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_node_index)
         && $stable(rsp_node_color) && $stable(rsp_color_overflow))
      else $error("stalled response changed");

   a_first_node: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !seen_ff |-> rsp_node_index == '0 && rsp_node_color == '0
         && !rsp_color_overflow)
      else $error("first response after reset is not node 0 with color 0");

   a_node_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_ff |-> rsp_node_index == '0
         || rsp_node_index == last_index_ff + ggc_pkg::INDEX_W'(1))
      else $error("node index out of sequence");

   a_overflow_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_color_overflow |->
         rsp_node_color == ggc_pkg::COLOR_W'(MAX_COLORS - 1))
      else $error("overflow without saturated color");

endmodule

bind greedy_graph_coloring_unit ggc_protocol_checker #(
   .MAX_COLORS (MAX_COLORS)
) u_ggc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_node_index     (rsp_node_index),
   .rsp_node_color     (rsp_node_color),
   .rsp_color_overflow (rsp_color_overflow)
);
